FILE: rtl/bpa_pkg.sv
// ============================================================================
// BPS patch apply engine package
// Shared constants, codes, queue entry type and CRC helpers.
// ============================================================================
package bpa_pkg;

    localparam int ADDR_BITS    = 22;
    localparam int MEM_DEPTH    = 1 << ADDR_BITS;
    localparam int PLEN_BITS    = 27;
    localparam int QDEPTH       = 2;
    localparam int FOOTER_BYTES = 12;
    localparam int CRC_BYTES    = 4;
    localparam int SIG_BYTES    = 4;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [ADDR_BITS:0]   t_size;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [31:0] SIG_WORD    = 32'h42505331;
    localparam logic [PLEN_BITS-1:0] PLEN_RESET = PLEN_BITS'(19);

    // Input functions.
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_PATCH  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_NEWJOB = 2'd3;

    // Configuration register indexes.
    localparam logic [7:0] CFG_PATCH_LENGTH = 8'd0;
    localparam logic [7:0] CFG_VALIDATE     = 8'd1;

    // Status codes.
    localparam logic [3:0] ST_BUSY       = 4'd0;
    localparam logic [3:0] ST_OK         = 4'd1;
    localparam logic [3:0] ST_BAD_SIG    = 4'd2;
    localparam logic [3:0] ST_MALFORMED  = 4'd3;
    localparam logic [3:0] ST_PATCH_CRC  = 4'd4;
    localparam logic [3:0] ST_SOURCE_CRC = 4'd5;
    localparam logic [3:0] ST_SREAD_OOB  = 4'd6;
    localparam logic [3:0] ST_SCOPY_OOB  = 4'd7;
    localparam logic [3:0] ST_TCOPY_OOB  = 4'd8;
    localparam logic [3:0] ST_TARGET_CRC = 4'd9;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd10;

    // Operations handed from the parser to the executor.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_NEWJOB  = 4'd1,
        OP_SRCW    = 4'd2,
        OP_SIZEERR = 4'd3,
        OP_PUT     = 4'd4,
        OP_SREAD   = 4'd5,
        OP_SCOPY   = 4'd6,
        OP_TCOPY   = 4'd7,
        OP_READ    = 4'd8
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        fin;   // last patch byte: resolve the final status
        logic [3:0]  pre;   // status already settled by the parser, else zero
        logic        chk;   // run the target CRC pass
        logic [31:0] tcrc;  // expected target CRC
        logic [63:0] len;
        logic [63:0] ofs;
        logic [7:0]  data;
        t_addr       addr;
        t_size       dts;   // declared target size after this item
    } t_entry;

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] byteswap(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

FILE: rtl/bpa_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port, registered read data.
// ============================================================================
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bpa_queue.sv
// ============================================================================
// Operation queue
// Short FIFO of parsed operations between the parser and the executor.
// ============================================================================
module bpa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bpa_pkg::t_entry i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output bpa_pkg::t_entry o_data
);
    import bpa_pkg::*;

    localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_BITS = $clog2(QDEPTH + 1);

    t_entry              r_mem [QDEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wptr;
    logic [PTR_BITS-1:0] n_rptr;
    logic [CNT_BITS-1:0] n_count;

    assign o_full  = (r_count == CNT_BITS'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_BITS'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_BITS'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(QDEPTH))
        else $error("queue count exceeds depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |=> (r_rptr != $past(r_rptr)) || (QDEPTH == 1))
        else $error("read pointer did not advance on pop");

endmodule

FILE: rtl/bpa_front.sv
// ============================================================================
// Patch parser
// Holds the configuration, takes every input item, walks the BPS syntax and
// emits one operation per item for the executor.
// ============================================================================
module bpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_take,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_data_byte,
    input  logic [bpa_pkg::ADDR_BITS-1:0] i_address,
    output bpa_pkg::t_entry               o_entry
);
    import bpa_pkg::*;

    typedef enum logic [10:0] {
        PH_SIG     = 11'b00000000001,
        PH_SRCSZ   = 11'b00000000010,
        PH_TGTSZ   = 11'b00000000100,
        PH_METALEN = 11'b00000001000,
        PH_META    = 11'b00000010000,
        PH_CMD     = 11'b00000100000,
        PH_TRDATA  = 11'b00001000000,
        PH_OFFSET  = 11'b00010000000,
        PH_FOOTER  = 11'b00100000000,
        PH_HALT    = 11'b01000000000,
        PH_DONE    = 11'b10000000000
    } t_phase;

    localparam logic [3:0] VSH_MAX = 4'd10;

    logic [PLEN_BITS-1:0] r_plen;
    logic                 r_chk;
    t_phase               r_phase,  n_phase;
    logic [63:0]          r_acc,    n_acc;
    logic [3:0]           r_vshift, n_vshift;
    logic [63:0]          r_rem,    n_rem;
    logic [PLEN_BITS-1:0] r_pbs,    n_pbs;
    t_size                r_dts,    n_dts;
    logic [31:0]          r_pcrc,   n_pcrc;
    logic [31:0]          r_scrc,   n_scrc;
    logic [63:0]          r_fs0,    n_fs0;
    logic [31:0]          r_fs1,    n_fs1;
    logic [3:0]           r_err,    n_err;
    logic                 r_tcopy,  n_tcopy;

    logic [PLEN_BITS-1:0] w_bound;
    logic [6:0]           w_sh;
    logic [63:0]          w_vsum;
    logic [63:0]          w_vcont;
    logic [3:0]           w_vnsh;
    logic [63:0]          w_len;
    logic                 w_mal;
    t_entry               w_e;

    // Variable-length number step: the weight is a power of 128, so the
    // product is a shift.
    assign w_sh    = 7'(r_vshift) * 7'd7;
    assign w_vsum  = r_acc + ({57'd0, i_data_byte[6:0]} << w_sh);
    assign w_vcont = w_vsum + (64'd1 << (w_sh + 7'd7));
    assign w_vnsh  = (r_vshift == VSH_MAX) ? r_vshift : r_vshift + 4'd1;
    assign w_len   = {2'b00, w_vsum[63:2]} + 64'd1;
    assign w_bound = (r_plen >= PLEN_BITS'(FOOTER_BYTES)) ?
                     r_plen - PLEN_BITS'(FOOTER_BYTES) : '0;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_vshift = r_vshift;
        n_rem    = r_rem;
        n_pbs    = r_pbs;
        n_dts    = r_dts;
        n_pcrc   = r_pcrc;
        n_scrc   = r_scrc;
        n_fs0    = r_fs0;
        n_fs1    = r_fs1;
        n_err    = r_err;
        n_tcopy  = r_tcopy;
        w_mal    = 1'b0;
        w_e      = '0;
        w_e.op   = OP_NONE;
        w_e.data = i_data_byte;
        w_e.addr = i_address;
        w_e.len  = r_rem;

        case (i_func)
            FUNC_LOAD: begin
                if (r_pbs == '0 && r_phase != PH_DONE) begin
                    w_e.op = OP_SRCW;
                    n_scrc = crc_step(r_scrc, i_data_byte);
                end
            end
            FUNC_PATCH: begin
                if (r_phase != PH_DONE) begin
                    if (r_plen >= PLEN_BITS'(CRC_BYTES) &&
                        r_pbs < r_plen - PLEN_BITS'(CRC_BYTES)) begin
                        n_pcrc = crc_step(r_pcrc, i_data_byte);
                    end
                    n_fs1 = {r_fs1[23:0], r_fs0[63:56]};
                    n_fs0 = {r_fs0[55:0], i_data_byte};

                    case (r_phase)
                        PH_SIG: begin
                            n_acc = {r_acc[55:0], i_data_byte};
                            if (r_pbs >= PLEN_BITS'(SIG_BYTES - 1)) begin
                                if (n_acc[31:0] != SIG_WORD) begin
                                    n_err   = ST_BAD_SIG;
                                    n_phase = PH_HALT;
                                end else begin
                                    n_phase = PH_SRCSZ;
                                end
                                n_acc = '0;
                            end
                        end
                        PH_SRCSZ, PH_TGTSZ, PH_METALEN: begin
                            if (i_data_byte[7]) begin
                                n_acc    = '0;
                                n_vshift = '0;
                                if (r_phase == PH_TGTSZ) begin
                                    if (w_vsum > 64'(MEM_DEPTH)) begin
                                        n_dts  = t_size'(MEM_DEPTH);
                                        w_e.op = OP_SIZEERR;
                                    end else begin
                                        n_dts = w_vsum[ADDR_BITS:0];
                                    end
                                    n_phase = PH_METALEN;
                                end else if (r_phase == PH_SRCSZ) begin
                                    n_phase = PH_TGTSZ;
                                end else begin
                                    n_rem   = w_vsum;
                                    n_phase = (w_vsum != '0) ? PH_META : PH_CMD;
                                end
                            end else begin
                                n_acc    = w_vcont;
                                n_vshift = w_vnsh;
                            end
                        end
                        PH_META: begin
                            n_rem = r_rem - 64'd1;
                            if (n_rem == '0) begin
                                n_phase = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            if (r_pbs >= w_bound) begin
                                if (r_vshift != '0) begin
                                    n_err   = ST_MALFORMED;
                                    n_phase = PH_HALT;
                                end else begin
                                    n_phase = PH_FOOTER;
                                end
                            end else if (i_data_byte[7]) begin
                                n_acc    = '0;
                                n_vshift = '0;
                                n_rem    = w_len;
                                case (w_vsum[1:0])
                                    2'd0: begin
                                        w_e.op  = OP_SREAD;
                                        w_e.len = w_len;
                                    end
                                    2'd1: begin
                                        n_phase = PH_TRDATA;
                                    end
                                    2'd2: begin
                                        n_tcopy = 1'b0;
                                        n_phase = PH_OFFSET;
                                    end
                                    default: begin
                                        n_tcopy = 1'b1;
                                        n_phase = PH_OFFSET;
                                    end
                                endcase
                            end else begin
                                n_acc    = w_vcont;
                                n_vshift = w_vnsh;
                            end
                        end
                        PH_TRDATA: begin
                            if (r_pbs >= w_bound) begin
                                n_err   = ST_MALFORMED;
                                n_phase = PH_HALT;
                            end else begin
                                w_e.op = OP_PUT;
                                n_rem  = r_rem - 64'd1;
                                if (n_rem == '0) begin
                                    n_phase = PH_CMD;
                                end
                            end
                        end
                        PH_OFFSET: begin
                            if (r_pbs >= w_bound) begin
                                n_err   = ST_MALFORMED;
                                n_phase = PH_HALT;
                            end else if (i_data_byte[7]) begin
                                n_acc    = '0;
                                n_vshift = '0;
                                w_e.op   = r_tcopy ? OP_TCOPY : OP_SCOPY;
                                w_e.ofs  = w_vsum;
                                n_phase  = PH_CMD;
                            end else begin
                                n_acc    = w_vcont;
                                n_vshift = w_vnsh;
                            end
                        end
                        default: begin
                        end
                    endcase

                    n_pbs = r_pbs + 1'b1;
                    if (n_pbs >= r_plen) begin
                        // Ending anywhere but between commands is malformed.
                        w_mal = (n_phase != PH_HALT) &&
                                (n_phase == PH_SIG || n_phase == PH_SRCSZ ||
                                 n_phase == PH_TGTSZ || n_phase == PH_METALEN ||
                                 n_phase == PH_META || n_phase == PH_TRDATA ||
                                 n_phase == PH_OFFSET ||
                                 (n_phase == PH_CMD && n_vshift != '0) ||
                                 r_plen < PLEN_BITS'(FOOTER_BYTES));
                        if (w_mal) begin
                            n_err = ST_MALFORMED;
                        end
                        w_e.fin = 1'b1;
                        w_e.chk = r_chk;
                        w_e.tcrc = byteswap(n_fs0[63:32]);
                        if (n_err != ST_BUSY) begin
                            w_e.pre = n_err;
                        end else if (byteswap(n_fs0[31:0]) != ~n_pcrc) begin
                            w_e.pre = ST_PATCH_CRC;
                        end else if (r_chk && byteswap(n_fs1) != ~r_scrc) begin
                            w_e.pre = ST_SOURCE_CRC;
                        end else begin
                            w_e.pre = ST_BUSY;
                        end
                        n_phase = PH_DONE;
                    end
                end
            end
            FUNC_READ: begin
                w_e.op = OP_READ;
            end
            default: begin
                w_e.op   = OP_NEWJOB;
                n_phase  = PH_SIG;
                n_acc    = '0;
                n_vshift = '0;
                n_rem    = '0;
                n_pbs    = '0;
                n_dts    = '0;
                n_pcrc   = CRC_INIT;
                n_scrc   = CRC_INIT;
                n_fs0    = '0;
                n_fs1    = '0;
                n_err    = ST_BUSY;
                n_tcopy  = 1'b0;
            end
        endcase
        w_e.dts = n_dts;
    end

    assign o_entry = w_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= PLEN_RESET;
            r_chk    <= 1'b1;
            r_phase  <= PH_SIG;
            r_acc    <= '0;
            r_vshift <= '0;
            r_rem    <= '0;
            r_pbs    <= '0;
            r_dts    <= '0;
            r_pcrc   <= CRC_INIT;
            r_scrc   <= CRC_INIT;
            r_fs0    <= '0;
            r_fs1    <= '0;
            r_err    <= ST_BUSY;
            r_tcopy  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PATCH_LENGTH: r_plen <= i_cfg_data[PLEN_BITS-1:0];
                    CFG_VALIDATE:     r_chk  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_take) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_vshift <= n_vshift;
                r_rem    <= n_rem;
                r_pbs    <= n_pbs;
                r_dts    <= n_dts;
                r_pcrc   <= n_pcrc;
                r_scrc   <= n_scrc;
                r_fs0    <= n_fs0;
                r_fs1    <= n_fs1;
                r_err    <= n_err;
                r_tcopy  <= n_tcopy;
            end
        end
    end

endmodule

FILE: rtl/bpa_back.sv
// ============================================================================
// Action executor
// Carries out queued operations on the source and target memories, resolves
// the final status and holds the result register.
// ============================================================================
module bpa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_entry_valid,
    input  bpa_pkg::t_entry             i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [3:0]                  o_status,
    output logic [7:0]                  o_read_byte,
    output logic [bpa_pkg::ADDR_BITS:0] o_target_length,
    output logic                        o_done_res
);
    import bpa_pkg::*;

    typedef enum logic [11:0] {
        BK_IDLE     = 12'b000000000001,
        BK_EXEC     = 12'b000000000010,
        BK_SREAD_RD = 12'b000000000100,
        BK_SREAD_WR = 12'b000000001000,
        BK_COPY     = 12'b000000010000,
        BK_COPY_WR  = 12'b000000100000,
        BK_READ     = 12'b000001000000,
        BK_FIN      = 12'b000010000000,
        BK_CRC      = 12'b000100000000,
        BK_CRC_WAIT = 12'b001000000000,
        BK_EMIT     = 12'b010000000000,
        BK_SPARE    = 12'b100000000000
    } t_bstate;

    t_bstate     r_state,  n_state;
    t_entry      r_cur;
    t_size       r_wo,     n_wo;
    t_size       r_sc,     n_sc;
    logic [63:0] r_sp,     n_sp;
    logic [63:0] r_tp,     n_tp;
    logic [63:0] r_p,      n_p;
    logic [63:0] r_n,      n_n;
    logic [3:0]  r_err,    n_err;
    logic        r_done,   n_done;
    logic [3:0]  r_status, n_status;
    logic [31:0] r_crc,    n_crc;
    t_size       r_i,      n_i;
    logic [7:0]  r_rd,     n_rd;
    logic        r_ovalid, n_ovalid;
    logic [3:0]  r_o_status;
    logic [7:0]  r_o_rd;
    t_size       r_o_tl;
    logic        r_o_done;
    logic        w_load;

    logic        src_we;
    t_addr       src_raddr;
    logic [7:0]  src_rdata;
    logic        tgt_we;
    logic [7:0]  tgt_wdata;
    t_addr       tgt_raddr;
    logic [7:0]  tgt_rdata;

    logic        w_scopy;
    logic [63:0] w_lim;
    logic        w_room;
    logic        w_copy_bad;
    logic        w_tail_bad;
    logic [63:0] w_ptr;
    logic [63:0] w_mag;
    logic [63:0] w_newp;
    logic [3:0]  w_copy_err;

    bpa_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (r_cur.addr),
        .i_wdata (r_cur.data),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    bpa_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (r_wo[ADDR_BITS-1:0]),
        .i_wdata (tgt_wdata),
        .i_raddr (tgt_raddr),
        .o_rdata (tgt_rdata)
    );

    assign w_scopy    = (r_cur.op == OP_SCOPY);
    assign w_lim      = 64'(w_scopy ? r_sc : r_wo);
    assign w_room     = (r_wo < r_cur.dts);
    assign w_copy_bad = r_p[63] || (r_p >= w_lim);
    assign w_tail_bad = w_copy_bad || (r_n > w_lim - r_p);
    assign w_ptr      = w_scopy ? r_sp : r_tp;
    assign w_mag      = {1'b0, r_cur.ofs[63:1]};
    assign w_newp     = r_cur.ofs[0] ? w_ptr - w_mag : w_ptr + w_mag;
    assign w_copy_err = w_scopy ? ST_SCOPY_OOB : ST_TCOPY_OOB;

    assign o_pop = (r_state == BK_IDLE) && i_entry_valid;

    always_comb begin
        n_state   = r_state;
        n_wo      = r_wo;
        n_sc      = r_sc;
        n_sp      = r_sp;
        n_tp      = r_tp;
        n_p       = r_p;
        n_n       = r_n;
        n_err     = r_err;
        n_done    = r_done;
        n_status  = r_status;
        n_crc     = r_crc;
        n_i       = r_i;
        n_rd      = r_rd;
        n_ovalid  = r_ovalid && !i_ready;
        w_load    = 1'b0;
        src_we    = 1'b0;
        src_raddr = r_wo[ADDR_BITS-1:0];
        tgt_we    = 1'b0;
        tgt_wdata = r_cur.data;
        tgt_raddr = r_cur.addr;

        case (r_state)
            BK_IDLE: begin
                if (i_entry_valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_rd    = 8'd0;
                n_state = BK_FIN;
                case (r_cur.op)
                    OP_NEWJOB: begin
                        n_wo     = '0;
                        n_sc     = '0;
                        n_sp     = '0;
                        n_tp     = '0;
                        n_err    = ST_BUSY;
                        n_done   = 1'b0;
                        n_status = ST_BUSY;
                    end
                    OP_SRCW: begin
                        src_we = 1'b1;
                        if (r_sc < t_size'(MEM_DEPTH)) begin
                            n_sc = r_sc + 1'b1;
                        end
                    end
                    OP_SIZEERR: begin
                        if (r_err == ST_BUSY) begin
                            n_err = ST_TOO_LARGE;
                        end
                    end
                    OP_PUT: begin
                        if (r_err == ST_BUSY && w_room) begin
                            tgt_we = 1'b1;
                            n_wo   = r_wo + 1'b1;
                        end
                    end
                    OP_SREAD: begin
                        if (r_err == ST_BUSY) begin
                            if (({1'b0, 64'(r_wo)} + {1'b0, r_cur.len}) > 65'(r_sc)) begin
                                n_err = ST_SREAD_OOB;
                            end else begin
                                n_n     = r_cur.len;
                                n_state = BK_SREAD_RD;
                            end
                        end
                    end
                    OP_SCOPY, OP_TCOPY: begin
                        if (w_scopy) begin
                            n_sp = w_newp;
                        end else begin
                            n_tp = w_newp;
                        end
                        if (r_err == ST_BUSY) begin
                            n_p     = w_newp;
                            n_n     = r_cur.len;
                            n_state = BK_COPY;
                        end
                    end
                    OP_READ: begin
                        if ({1'b0, r_cur.addr} < r_wo) begin
                            n_state = BK_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            BK_SREAD_RD: begin
                if (r_n != '0 && w_room) begin
                    n_state = BK_SREAD_WR;
                end else begin
                    n_state = BK_FIN;
                end
            end
            BK_SREAD_WR: begin
                tgt_we    = 1'b1;
                tgt_wdata = src_rdata;
                n_wo      = r_wo + 1'b1;
                n_n       = r_n - 64'd1;
                n_state   = BK_SREAD_RD;
            end
            BK_COPY: begin
                src_raddr = r_p[ADDR_BITS-1:0];
                tgt_raddr = r_p[ADDR_BITS-1:0];
                n_state   = BK_FIN;
                if (r_n != '0 && w_room) begin
                    if (w_copy_bad) begin
                        n_err = w_copy_err;
                    end else begin
                        n_state = BK_COPY_WR;
                    end
                end else if (r_n != '0) begin
                    // Clipped by the target size: only the bounds are checked.
                    if (w_tail_bad) begin
                        n_err = w_copy_err;
                    end else if (w_scopy) begin
                        n_sp = r_p + r_n;
                    end else begin
                        n_tp = r_p + r_n;
                    end
                end else if (w_scopy) begin
                    n_sp = r_p;
                end else begin
                    n_tp = r_p;
                end
            end
            BK_COPY_WR: begin
                tgt_we    = 1'b1;
                tgt_wdata = w_scopy ? src_rdata : tgt_rdata;
                n_wo      = r_wo + 1'b1;
                n_p       = r_p + 64'd1;
                n_n       = r_n - 64'd1;
                n_state   = BK_COPY;
            end
            BK_READ: begin
                n_rd    = tgt_rdata;
                n_state = BK_FIN;
            end
            BK_FIN: begin
                n_state = BK_EMIT;
                if (r_cur.fin) begin
                    n_done = 1'b1;
                    if (r_cur.pre != ST_BUSY) begin
                        n_status = r_cur.pre;
                    end else if (r_err != ST_BUSY) begin
                        n_status = r_err;
                    end else if (r_cur.chk) begin
                        n_done  = 1'b0;
                        n_crc   = CRC_INIT;
                        n_i     = '0;
                        n_state = BK_CRC;
                    end else begin
                        n_status = ST_OK;
                    end
                end
            end
            BK_CRC: begin
                tgt_raddr = r_i[ADDR_BITS-1:0];
                if (r_i == r_cur.dts) begin
                    n_status = (~r_crc == r_cur.tcrc) ? ST_OK : ST_TARGET_CRC;
                    n_done   = 1'b1;
                    n_state  = BK_EMIT;
                end else if (r_i < r_wo) begin
                    n_state = BK_CRC_WAIT;
                end else begin
                    n_crc = crc_step(r_crc, 8'd0);
                    n_i   = r_i + 1'b1;
                end
            end
            BK_CRC_WAIT: begin
                n_crc   = crc_step(r_crc, tgt_rdata);
                n_i     = r_i + 1'b1;
                n_state = BK_CRC;
            end
            BK_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    w_load   = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_wo     <= '0;
            r_sc     <= '0;
            r_sp     <= '0;
            r_tp     <= '0;
            r_err    <= ST_BUSY;
            r_done   <= 1'b0;
            r_status <= ST_BUSY;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wo     <= n_wo;
            r_sc     <= n_sc;
            r_sp     <= n_sp;
            r_tp     <= n_tp;
            r_err    <= n_err;
            r_done   <= n_done;
            r_status <= n_status;
            r_ovalid <= n_ovalid;
        end
        r_p   <= n_p;
        r_n   <= n_n;
        r_crc <= n_crc;
        r_i   <= n_i;
        r_rd  <= n_rd;
        if (o_pop) begin
            r_cur <= i_entry;
        end
        if (w_load) begin
            r_o_status <= r_done ? r_status : ST_BUSY;
            r_o_rd     <= r_rd;
            r_o_tl     <= r_cur.dts;
            r_o_done   <= r_done;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_read_byte     = r_o_rd;
    assign o_target_length = r_o_tl;
    assign o_done_res      = r_o_done;

endmodule

FILE: rtl/bps_patch_apply_engine.sv
// ============================================================================
// BPS patch apply engine
// Top level: parser, operation queue and executor with the two byte stores.
// ============================================================================
// Each input transaction yields exactly one result transaction. A job starts
// with func 3; source bytes are loaded first (func 0, in address order), then
// the patch streams in one byte per transaction (func 1), and the target can
// be read back with func 2. The parser takes one transaction per cycle into a
// two-entry queue, so the input side only stalls when the executor falls
// behind. An ordinary item passes the executor's exec, finish and emit
// states; each target byte of a SourceRead, SourceCopy or TargetCopy adds
// a registered memory read followed by a write through the target RAM's
// write port. The last patch byte, when checksums are validated and no
// earlier error decided the status, also runs the target CRC pass over the
// written target bytes read back and zeros up to the declared target size.
// Configuration writes are taken at any time and must only be issued while
// the block is idle. Neither byte store is cleared; target bytes at or past
// the write offset read back as zero.
module bps_patch_apply_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // Item channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_data_byte,
    input  logic [bpa_pkg::ADDR_BITS-1:0] i_address,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3:0]                    o_status,
    output logic [7:0]                    o_read_byte,
    output logic [bpa_pkg::ADDR_BITS:0]   o_target_length,
    output logic                          o_done_res
);
    import bpa_pkg::*;

    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    logic   w_take;
    t_entry w_push_entry;
    t_entry w_pop_entry;

    // Registers are always writable; the block is idle by contract.
    assign o_cfg_ready = 1'b1;

    // An item transaction completes whenever the queue has room.
    assign o_ready = !q_full;
    assign w_take  = i_valid && o_ready;

    bpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_address   (i_address),
        .o_entry     (w_push_entry)
    );

    bpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_data  (w_push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (w_pop_entry)
    );

    // The executor owns both memories and the result register; a result
    // waiting for the consumer stalls parsing only once the queue is full.
    bpa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_valid   (q_valid),
        .i_entry         (w_pop_entry),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_read_byte     (o_read_byte),
        .o_target_length (o_target_length),
        .o_done_res      (o_done_res)
    );

endmodule
